[rtl/pisc_pkg.sv]
// Package with the shape codes, register indexes and fixed-point constants of the classifier.
`timescale 1ns / 1ps

package pisc_pkg;

  // Fraction bits of the Q16.16 coordinate format.
  localparam int unsigned FRAC_BITS = 16;

  // Width of the configuration register index.
  localparam int unsigned REG_IDX_W = 3;

  // Width of the shape code register.
  localparam int unsigned KIND_W = 4;

  typedef enum logic [KIND_W-1:0] {
    SHAPE_SPHERE   = 4'd0,
    SHAPE_CONE     = 4'd1,
    SHAPE_CYLINDER = 4'd2,
    SHAPE_BOX      = 4'd3,
    SHAPE_X_GE     = 4'd4,
    SHAPE_X_LE     = 4'd5,
    SHAPE_Y_GE     = 4'd6,
    SHAPE_Y_LE     = 4'd7,
    SHAPE_Z_GE     = 4'd8,
    SHAPE_Z_LE     = 4'd9
  } shape_kind_e;

  typedef enum logic [REG_IDX_W-1:0] {
    REG_SHAPE_KIND = 3'd0,
    REG_PARAM_A    = 3'd1,
    REG_PARAM_B    = 3'd2,
    REG_PARAM_C    = 3'd3,
    REG_PARAM_D    = 3'd4,
    REG_PARAM_E    = 3'd5,
    REG_PARAM_F    = 3'd6
  } reg_idx_e;

endpackage

[rtl/point_in_shape_classifier.sv]
// Top level of the point-in-shape classifier: a five-stage pipeline of exact fixed-point tests.
`timescale 1ns / 1ps

// The block decides whether a 3-D point in signed Q16.16 lies inside or on a configured
// primitive: sphere, z-bounded cone, z-bounded cylinder, axis-aligned box or one of six
// half-spaces. All differences, squares and products are kept at full width, so each
// comparison is exact.
// Configuration: the shape code and parameters a to f are written through cfg_we_i,
// cfg_idx_i and cfg_data_i, one register per clock; the user must write them only while no
// transaction is in flight, as the block does not enforce it. Writes to index 7 are ignored.
// Input: a transaction is taken at each rising edge where start_i is high and busy_o is low.
// busy_o is always low, so a new point may be offered in every cycle.
// Output: done_o is high for exactly one cycle with inside_res_o, after the point has passed
// the stage registers and the output register. Results leave in the order the points arrived.
// Throughput is one point per cycle; the pipeline depth is set by the chain of
// difference, square, partial product, wide sum and wide compare stages that the cone
// test needs, since its slope term is a product of two squares.
// Reset clears the pipeline valid bits and loads the register reset values (sphere of
// radius 1.0 at the origin, z bounds 0 to 1.0). The receiver cannot hold results off, so
// the pipeline never stalls.
module point_in_shape_classifier #(
  parameter int unsigned COORD_BITS = 32
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         cfg_we_i,
  input  logic [pisc_pkg::REG_IDX_W-1:0] cfg_idx_i,
  input  logic [COORD_BITS-1:0]        cfg_data_i,
  input  logic                         start_i,
  output logic                         busy_o,
  input  logic signed [COORD_BITS-1:0] point_x_i,
  input  logic signed [COORD_BITS-1:0] point_y_i,
  input  logic signed [COORD_BITS-1:0] point_z_i,
  output logic                         done_o,
  output logic                         inside_res_o
);

  import pisc_pkg::*;

  // Magnitude of a difference, width of a square, of a planar sum, of a spherical sum and of the cone compare.
  localparam int unsigned MW  = COORD_BITS + 1;
  localparam int unsigned SQW = 2 * MW;
  localparam int unsigned PW  = SQW + 1;
  localparam int unsigned SW  = SQW + 2;
  localparam int unsigned CW  = 4 * MW;

  localparam logic [COORD_BITS-1:0] ONE_Q = COORD_BITS'(1) << FRAC_BITS;

  // Configuration registers.
  logic [KIND_W-1:0]            shape_kind_q;
  logic signed [COORD_BITS-1:0] param_a_q, param_b_q, param_c_q;
  logic signed [COORD_BITS-1:0] param_d_q, param_e_q, param_f_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      shape_kind_q <= SHAPE_SPHERE;
      param_a_q    <= '0;
      param_b_q    <= '0;
      param_c_q    <= '0;
      param_d_q    <= ONE_Q;
      param_e_q    <= '0;
      param_f_q    <= ONE_Q;
    end else if (cfg_we_i) begin
      unique case (reg_idx_e'(cfg_idx_i))
        REG_SHAPE_KIND: shape_kind_q <= cfg_data_i[KIND_W-1:0];
        REG_PARAM_A:    param_a_q    <= cfg_data_i;
        REG_PARAM_B:    param_b_q    <= cfg_data_i;
        REG_PARAM_C:    param_c_q    <= cfg_data_i;
        REG_PARAM_D:    param_d_q    <= cfg_data_i;
        REG_PARAM_E:    param_e_q    <= cfg_data_i;
        REG_PARAM_F:    param_f_q    <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // The pipeline always advances, so it never pushes back on the source.
  assign busy_o = 1'b0;

  logic accept;
  assign accept = start_i & ~busy_o;

  // ---------------------------------------------------------------------------------------
  // Stage 1: centred differences as magnitudes, and all the plain range compares.
  // ---------------------------------------------------------------------------------------
  logic signed [MW-1:0] dx, dy, dz;
  logic [MW-1:0]        mx, my, mz;
  logic                 zin, flat_ok;

  assign dx = MW'(point_x_i) - MW'(param_a_q);
  assign dy = MW'(point_y_i) - MW'(param_b_q);
  assign dz = MW'(point_z_i) - MW'(param_c_q);
  assign mx = dx[MW-1] ? MW'(-dx) : MW'(dx);
  assign my = dy[MW-1] ? MW'(-dy) : MW'(dy);
  assign mz = dz[MW-1] ? MW'(-dz) : MW'(dz);

  assign zin = (point_z_i >= param_e_q) && (point_z_i <= param_f_q);

  // Box and half-space outcomes need no arithmetic beyond a compare, so they are settled here.
  always_comb begin
    case (shape_kind_q)
      SHAPE_BOX:  flat_ok = (point_x_i >= param_a_q) && (point_x_i <= param_c_q) &&
                            (point_y_i >= param_b_q) && (point_y_i <= param_d_q) && zin;
      SHAPE_X_GE: flat_ok = point_x_i >= param_a_q;
      SHAPE_X_LE: flat_ok = point_x_i <= param_a_q;
      SHAPE_Y_GE: flat_ok = point_y_i >= param_b_q;
      SHAPE_Y_LE: flat_ok = point_y_i <= param_b_q;
      SHAPE_Z_GE: flat_ok = point_z_i >= param_e_q;
      SHAPE_Z_LE: flat_ok = point_z_i <= param_e_q;
      default:    flat_ok = 1'b0;
    endcase
  end

  logic          s1_valid_q;
  logic [MW-1:0] s1_mx_q, s1_my_q, s1_mz_q;
  logic          s1_zin_q, s1_flat_q;

  // ---------------------------------------------------------------------------------------
  // Stage 2: squares of the differences and the cone slope product |d| * |dz|.
  // ---------------------------------------------------------------------------------------
  logic signed [COORD_BITS-1:0] dneg;
  logic [MW-1:0]                md;

  assign dneg = -param_d_q;
  assign md   = param_d_q[COORD_BITS-1] ? {1'b0, dneg} : {1'b0, param_d_q};

  logic           s2_valid_q;
  logic [SQW-1:0] s2_sx_q, s2_sy_q, s2_sz_q, s2_m_q;
  logic           s2_zin_q, s2_flat_q;
  // The radius square depends only on configuration, so it is simply refreshed each cycle.
  logic [SQW-1:0] rr_q;

  // ---------------------------------------------------------------------------------------
  // Stage 3: planar and spherical sums, and the three partial products of (|d| * |dz|)^2.
  // ---------------------------------------------------------------------------------------
  logic [MW-1:0] m_hi, m_lo;

  assign m_hi = s2_m_q[SQW-1:MW];
  assign m_lo = s2_m_q[MW-1:0];

  logic           s3_valid_q;
  logic [PW-1:0]  s3_planar_q;
  logic [SW-1:0]  s3_sph_q;
  logic [SQW-1:0] s3_hh_q, s3_hl_q, s3_ll_q;
  logic           s3_zin_q, s3_flat_q;

  // ---------------------------------------------------------------------------------------
  // Stage 4: sum of the partial products, sphere and cylinder compares.
  // ---------------------------------------------------------------------------------------
  logic [CW-1:0] p2;

  assign p2 = (CW'(s3_hh_q) << SQW) + (CW'(s3_hl_q) << (MW + 1)) + CW'(s3_ll_q);

  logic          s4_valid_q;
  logic [PW-1:0] s4_planar_q;
  logic [CW-1:0] s4_p2_q;
  logic          s4_sph_ok_q, s4_cyl_ok_q;
  logic          s4_zin_q, s4_flat_q;

  // ---------------------------------------------------------------------------------------
  // Stage 5: cone compare and selection of the outcome by shape code.
  // ---------------------------------------------------------------------------------------
  logic cone_ok;
  logic inside_d;

  assign cone_ok = (CW'(s4_planar_q) << (2 * FRAC_BITS)) <= s4_p2_q;

  always_comb begin
    unique case (shape_kind_q)
      SHAPE_SPHERE:   inside_d = s4_sph_ok_q;
      SHAPE_CONE:     inside_d = cone_ok && s4_zin_q;
      SHAPE_CYLINDER: inside_d = s4_cyl_ok_q && s4_zin_q;
      default:        inside_d = s4_flat_q;
    endcase
  end

  logic done_q;
  logic inside_q;

  // Valid bits of the pipeline.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
      s2_valid_q <= 1'b0;
      s3_valid_q <= 1'b0;
      s4_valid_q <= 1'b0;
      done_q     <= 1'b0;
    end else begin
      s1_valid_q <= accept;
      s2_valid_q <= s1_valid_q;
      s3_valid_q <= s2_valid_q;
      s4_valid_q <= s3_valid_q;
      done_q     <= s4_valid_q;
    end
  end

  // Payload of the pipeline; it travels alongside the valid bits and needs no reset.
  always_ff @(posedge clk_i) begin
    s1_mx_q   <= mx;
    s1_my_q   <= my;
    s1_mz_q   <= mz;
    s1_zin_q  <= zin;
    s1_flat_q <= flat_ok;

    s2_sx_q   <= SQW'(s1_mx_q) * SQW'(s1_mx_q);
    s2_sy_q   <= SQW'(s1_my_q) * SQW'(s1_my_q);
    s2_sz_q   <= SQW'(s1_mz_q) * SQW'(s1_mz_q);
    s2_m_q    <= SQW'(md) * SQW'(s1_mz_q);
    s2_zin_q  <= s1_zin_q;
    s2_flat_q <= s1_flat_q;
    rr_q      <= SQW'(md) * SQW'(md);

    s3_planar_q <= PW'(s2_sx_q) + PW'(s2_sy_q);
    s3_sph_q    <= SW'(s2_sx_q) + SW'(s2_sy_q) + SW'(s2_sz_q);
    s3_hh_q     <= SQW'(m_hi) * SQW'(m_hi);
    s3_hl_q     <= SQW'(m_hi) * SQW'(m_lo);
    s3_ll_q     <= SQW'(m_lo) * SQW'(m_lo);
    s3_zin_q    <= s2_zin_q;
    s3_flat_q   <= s2_flat_q;

    s4_planar_q <= s3_planar_q;
    s4_p2_q     <= p2;
    s4_sph_ok_q <= s3_sph_q <= SW'(rr_q);
    s4_cyl_ok_q <= s3_planar_q <= PW'(rr_q);
    s4_zin_q    <= s3_zin_q;
    s4_flat_q   <= s3_flat_q;

    inside_q <= inside_d;
  end

  assign done_o       = done_q;
  assign inside_res_o = inside_q;

endmodule
